// ===== hw/rtl/rdc_pkg.sv =====
package rdc_pkg;

	// Field widths
	localparam int VALUE_W = 31;
	localparam int DIGIT_W = 4;
	localparam int BASE_W  = 4;

	// Supported radix range
	localparam logic [BASE_W-1:0] BASE_MIN   = 4'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 4'd9;
	localparam logic [BASE_W-1:0] BASE_RESET = 4'd2;

	// Serial divider: quotient bits retired per cycle, padded dividend width
	localparam int STEP_BITS = 4;
	localparam int SHIFT_W   = 32;
	localparam int PASSES    = SHIFT_W / STEP_BITS;
	localparam int PASS_W    = $clog2(PASSES);
	localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(PASSES - 1);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_BASE = 1'b0;

	// Clamp the raw register to the supported radix range
	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] raw);
		logic [BASE_W-1:0] b;
		b = raw;
		if (raw < BASE_MIN) begin
			b = BASE_MIN;
		end else if (raw > BASE_MAX) begin
			b = BASE_MAX;
		end
		return b;
	endfunction

	// One restoring division step: shift in a dividend bit, subtract the base if it fits.
	// Returns {new remainder, quotient bit}.
	function automatic logic [DIGIT_W:0] div_step(input logic [DIGIT_W-1:0] rem,
			input logic din, input logic [BASE_W-1:0] b);
		logic [DIGIT_W:0] t;
		logic             q;
		t = {rem, din};
		q = 1'b0;
		if (t >= {1'b0, b}) begin
			t = t - {1'b0, b};
			q = 1'b1;
		end
		return {t[DIGIT_W-1:0], q};
	endfunction

endpackage

// ===== hw/rtl/rdc_ram.sv =====
module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/radix_digit_converter.sv =====
// Radix digit converter. Pulse start while busy is low to convert a 31-bit value to the
// base held in the base register (2 to 9; smaller settings act as 2, larger as 9). The
// digits come out most significant first, one per strobe cycle, with last high on the
// final digit; zero gives the single digit 0. Results are not held: the receiver must take
// each one in its strobe cycle. A serial divider retires four quotient bits per cycle to work
// out each digit in turn; the item then streams one digit per cycle out of the digit RAM. An
// item has at most 31 digits (in base 2), and its last strobe comes in the first cycle with
// busy low.
module radix_digit_converter import rdc_pkg::*; #(
	parameter int MAX_DIGITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] value,
	output logic               busy,
	output logic               strobe,
	output logic [DIGIT_W-1:0] digit,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic [BASE_W-1:0]    base_q;
	logic [BASE_W-1:0]    eff_base;
	logic [SHIFT_W-1:0]   shreg_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic                 nz_q;
	logic [PASS_W-1:0]    pass_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_nx;
	logic [AW-1:0]        idx_q;
	logic                 pend_s1;
	logic                 last_s1;
	logic [DIGIT_W-1:0]   rem_nx;
	logic [STEP_BITS-1:0] q_bits;
	logic                 ram_we;
	logic                 reg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (reg_wr && paddr[PADDR_W-1] == REG_BASE) begin
			base_q <= pwdata[BASE_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1] == REG_BASE) ? {{(PDATA_W-BASE_W){1'b0}}, base_q}
	                                               : '0;

	assign eff_base = clamp_base(base_q);

	// Retire STEP_BITS quotient bits from the top of the dividend shift register
	always_comb begin
		logic [DIGIT_W:0]   st;
		logic [DIGIT_W-1:0] r;
		r      = rem_q;
		q_bits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			st = div_step(r, shreg_q[SHIFT_W-1-i], eff_base);
			r  = st[DIGIT_W:1];
			q_bits[STEP_BITS-1-i] = st[0];
		end
		rem_nx = r;
	end

	// Count digits, saturating at the buffer depth
	assign cnt_nx = (cnt_q < MAX_CNT) ? cnt_q + 1'b1 : cnt_q;
	assign ram_we = (state_q == S_DIV) && (pass_q == PASS_LAST) && (cnt_q < MAX_CNT);

	// Digit buffer, least significant digit at address zero
	rdc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rem_nx),
		.raddr (idx_q),
		.rdata (digit)
	);

	// Sequencer: divide pass by pass, then read digits back from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			shreg_q <= '0;
			rem_q   <= '0;
			nz_q    <= 1'b0;
			pass_q  <= '0;
			idx_q   <= '0;
		end else begin
			pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						shreg_q <= {{(SHIFT_W-VALUE_W){1'b0}}, value};
						rem_q   <= '0;
						nz_q    <= 1'b0;
						pass_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					shreg_q <= {shreg_q[SHIFT_W-STEP_BITS-1:0], q_bits};
					rem_q   <= rem_nx;
					nz_q    <= nz_q || (|q_bits);
					pass_q  <= pass_q + 1'b1;
					if (pass_q == PASS_LAST) begin
						// Digit done: restart on the quotient or drain
						cnt_q <= cnt_nx;
						rem_q <= '0;
						nz_q  <= 1'b0;
						if (!(nz_q || (|q_bits))) begin
							idx_q   <= AW'(cnt_nx - 1'b1);
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					pend_s1 <= 1'b1;
					last_s1 <= (idx_q == '0);
					idx_q   <= idx_q - 1'b1;
					if (idx_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = pend_s1;
	assign last   = last_s1;

	// A transfer only follows a read issued in the drain state
	a_strobe_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == S_EMIT))
		else $error("digit transfer without a buffer read");

	// The partial remainder always stays below the base
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < eff_base))
		else $error("division remainder out of range");

	// The final digit leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> (state_q == S_IDLE))
		else $error("final digit while still busy");

	// An accepted item starts the divider
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_DIV && cnt_q == '0))
		else $error("accepted item did not start division");

endmodule

// ===== dv/radix_digit_converter_test.sv =====
`timescale 1ns / 1ps

module radix_digit_converter_test;
	import rdc_pkg::*;

	localparam int MAX_DIGITS = 32;
	localparam int DIR_ROWS = 25;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 50;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [PADDR_W-1:0] BASE_ADDR  = PADDR_W'(0);
	localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

	// One directed row: radix to program, value, and a typed expectation
	// (exp_count copies of exp_digit); exp_count of zero defers to the predictor.
	typedef struct packed {
		logic [BASE_W-1:0]  base_set;
		logic [VALUE_W-1:0] value;
		logic [5:0]         exp_count;
		logic [DIGIT_W-1:0] exp_digit;
	} conv_row_t;

	typedef struct {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} digit_exp_t;

	localparam conv_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
		'{4'd2,  31'd0,          6'd1,  4'd0},
		'{4'd2,  31'd1,          6'd1,  4'd1},
		'{4'd2,  31'h7FFFFFFF,   6'd31, 4'd1},
		'{4'd2,  31'h40000000,   6'd0,  4'd0},
		'{4'd2,  31'h55555555,   6'd0,  4'd0},
		'{4'd9,  31'd8,          6'd1,  4'd8},
		'{4'd9,  31'd80,         6'd2,  4'd8},
		'{4'd9,  31'd0,          6'd1,  4'd0},
		'{4'd9,  31'h7FFFFFFF,   6'd0,  4'd0},
		'{4'd9,  31'd9,          6'd0,  4'd0},
		'{4'd0,  31'd3,          6'd2,  4'd1},
		'{4'd0,  31'h7FFFFFFF,   6'd31, 4'd1},
		'{4'd1,  31'd1,          6'd1,  4'd1},
		'{4'd1,  31'd2,          6'd0,  4'd0},
		'{4'd15, 31'd728,        6'd3,  4'd8},
		'{4'd15, 31'h7FFFFFFF,   6'd0,  4'd0},
		'{4'd10, 31'd8,          6'd1,  4'd8},
		'{4'd10, 31'h2AAAAAAA,   6'd0,  4'd0},
		'{4'd5,  31'd4,          6'd1,  4'd4},
		'{4'd5,  31'd24,         6'd2,  4'd4},
		'{4'd5,  31'h7FFFFFFF,   6'd0,  4'd0},
		'{4'd3,  31'd26,         6'd3,  4'd2},
		'{4'd7,  31'h7FFFFFFF,   6'd0,  4'd0},
		'{4'd4,  31'h3FFFFFFF,   6'd15, 4'd3},
		'{4'd8,  31'h3FFFFFFF,   6'd10, 4'd7}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [VALUE_W-1:0] value = '0;
	logic               busy;
	logic               strobe;
	logic [DIGIT_W-1:0] digit;
	logic               last;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic [BASE_W-1:0]  cfg_base = BASE_RESET;
	digit_exp_t         pending_digits[$];
	digit_exp_t         head_digit;
	int                 mismatches = 0;
	int                 values_sent = 0;
	int                 digits_seen = 0;
	int                 radix_writes = 0;

	radix_digit_converter #(
		.MAX_DIGITS(MAX_DIGITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.value(value),
		.busy(busy),
		.strobe(strobe),
		.digit(digit),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Radix after clamping the raw register to two..nine
	function automatic int unsigned radix_now();
		int unsigned b;
		b = 32'(cfg_base);
		if (b < 2) begin
			b = 2;
		end
		if (b > 9) begin
			b = 9;
		end
		return b;
	endfunction

	// Divide down by the radix, then queue the digits most significant first
	task automatic queue_digits(input logic [VALUE_W-1:0] val);
		int unsigned b;
		int unsigned v;
		int unsigned n;
		int unsigned k;
		logic [DIGIT_W-1:0] rems [MAX_DIGITS];
		digit_exp_t e;
		b = radix_now();
		v = 32'(val);
		n = 0;
		do begin
			if (n < MAX_DIGITS) begin
				rems[n] = DIGIT_W'(v % b);
				n++;
			end
			v = v / b;
		end while (v != 0);
		for (k = n; k > 0; k--) begin
			e.digit = rems[k-1];
			e.last = (k == 1);
			pending_digits.push_back(e);
		end
	endtask

	// Hold start and value until the block takes the transfer
	task automatic send_value(input logic [VALUE_W-1:0] val, input int unsigned typed_count,
			input logic [DIGIT_W-1:0] typed_digit);
		digit_exp_t e;
		int unsigned i;
		start <= 1'b1;
		value <= val;
		do @(posedge clk); while (busy);
		if (typed_count == 0) begin
			queue_digits(val);
		end else begin
			for (i = 0; i < typed_count; i++) begin
				e.digit = typed_digit;
				e.last = (i == typed_count - 1);
				pending_digits.push_back(e);
			end
		end
		values_sent++;
	endtask

	// Drop start, then wait out every pending digit and the tail of the block
	task automatic drain();
		start <= 1'b0;
		value <= VALUE_W'($urandom);
		while (pending_digits.size() != 0 || busy) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register, then read the radix back in the same APB burst
	task automatic set_radix(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == BASE_ADDR) begin
			cfg_base = data[BASE_W-1:0];
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= BASE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[BASE_W-1:0] !== cfg_base) begin
			flag_mismatch($sformatf("base readback %0d, want %0d", prdata[BASE_W-1:0],
				cfg_base));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		radix_writes++;
	endtask

	// Small, full-range, shifted, radix powers or one less, all-ones or zero
	function automatic logic [VALUE_W-1:0] pick_value();
		longint unsigned p;
		int unsigned b;
		int unsigned k;
		int unsigned steps;
		b = radix_now();
		case ($urandom_range(0, 9))
			0, 1, 2: return VALUE_W'($urandom_range(0, 100));
			3, 4: return VALUE_W'($urandom);
			5, 6: begin
				p = 1;
				steps = $urandom_range(0, 30);
				for (k = 0; k < steps && p * b < 64'h80000000; k++) begin
					p = p * b;
				end
				if ($urandom_range(0, 1) == 1) begin
					p = p - 1;
				end
				return VALUE_W'(p);
			end
			7: return ($urandom_range(0, 1) == 1) ? '1 : '0;
			default: return VALUE_W'($urandom >> $urandom_range(1, 31));
		endcase
	endfunction

	// Check each digit strobe against the oldest pending digit
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			digits_seen++;
			if (pending_digits.size() == 0) begin
				flag_mismatch($sformatf("digit %0d last %0b with nothing pending", digit, last));
			end else begin
				head_digit = pending_digits.pop_front();
				if (digit !== head_digit.digit) begin
					flag_mismatch($sformatf("digit %0d, want %0d", digit, head_digit.digit));
				end
				if (last !== head_digit.last) begin
					flag_mismatch($sformatf("last %0b, want %0b", last, head_digit.last));
				end
			end
		end
	end

	initial begin
		int i;
		int ph;
		int n;
		int gap;
		logic [BASE_W-1:0] b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, first rows on the reset radix
		for (i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED_ROWS[i].base_set != cfg_base) begin
				drain();
				set_radix(BASE_ADDR, PDATA_W'(DIRECTED_ROWS[i].base_set));
			end
			send_value(DIRECTED_ROWS[i].value, 32'(DIRECTED_ROWS[i].exp_count),
				DIRECTED_ROWS[i].exp_digit);
		end

		// Random phases, each on its own radix setting
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: b = 4'd2;
				1: b = 4'd9;
				2: b = 4'd0;
				3: b = 4'd15;
				4: b = 4'd6;
				default: b = BASE_W'($urandom_range(0, 15));
			endcase
			if ($urandom_range(0, 2) == 0) begin
				set_radix(SPARE_ADDR, $urandom);
			end
			set_radix(BASE_ADDR, ($urandom & 32'hFFFF_FFF0) | PDATA_W'(b));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_value(pick_value(), 0, '0);
				// phases four and five run back to back with no idling
				if ((ph < 4 || ph > 5) && $urandom_range(0, 99) < 26) begin
					gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
						: $urandom_range(1, 8);
					start <= 1'b0;
					value <= VALUE_W'($urandom);
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Converted %0d values into %0d digits across %0d register writes",
			values_sent, digits_seen, radix_writes);
		$display("Radix settings covered both clamps, the reset value and random codes");
		if (mismatches == 0 && pending_digits.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Bail out if the handshake ever hangs
	initial begin
		#30_000_000;
		$display("Timed out with %0d digits pending", pending_digits.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
